/* hw/rtl/previous_prime_search_unit_macros.svh */
// Assertion macros shared by the previous prime search RTL.
`ifndef PREVIOUS_PRIME_SEARCH_UNIT_MACROS_SVH
`define PREVIOUS_PRIME_SEARCH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/pps_pkg.sv */
// Shared constants and types of the previous prime search unit.
`default_nettype none

package pps_pkg;

  localparam int VALUE_BITS = 16;
  // Trial divisors never exceed floor(sqrt(candidate)) + 1.
  localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1;
  // Square of the trial divisor, with headroom for the last step.
  localparam int SQ_BITS    = VALUE_BITS + 2;
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } pps_div_status_t;

endpackage

`default_nettype wire

/* hw/rtl/pps_rem_unit.sv */
// Bit-serial restoring remainder unit: one quotient bit per cycle.
`default_nettype none

module pps_rem_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pps_pkg::VALUE_BITS-1:0] dividend,
  input  wire logic [pps_pkg::DIV_BITS-1:0]   divisor,
  output pps_pkg::pps_div_status_t           status
);

  logic [pps_pkg::VALUE_BITS-1:0] dvd;
  logic [pps_pkg::DIV_BITS-1:0]   dvs;
  logic [pps_pkg::DIV_BITS-1:0]   rem;
  logic [pps_pkg::DIV_BITS-1:0]   rem_next;
  logic [pps_pkg::DIV_BITS:0]     trial;
  logic [pps_pkg::CNT_BITS-1:0]   cnt;
  logic                           busy;
  logic                           done;

  // The partial remainder stays below the divisor, so it fits DIV_BITS.
  always_comb begin
    trial = {rem, dvd[pps_pkg::VALUE_BITS-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = pps_pkg::DIV_BITS'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[pps_pkg::DIV_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == pps_pkg::CNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= pps_pkg::CNT_BITS'(pps_pkg::VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - pps_pkg::CNT_BITS'(1);
        if (cnt == pps_pkg::CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[pps_pkg::VALUE_BITS-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign status.zero = (rem == '0);

endmodule

`default_nettype wire

/* hw/rtl/previous_prime_search_unit.sv */
// Values below 3 go from acceptance through the finish state to the output register with
// found low. Otherwise, for each candidate from value - 1 downward, the check state starts
// a bit-serial trial division per divisor from two up, and the result is then loaded into
// the output register in the finish state, which waits while the output is stalled.
// One item at a time; a new item is taken once the result is registered.
// Reset is synchronous and clears the sequencer, the divider control and out_valid.
`default_nettype none

module previous_prime_search_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [pps_pkg::VALUE_BITS-1:0] value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                found,
  output logic [pps_pkg::VALUE_BITS-1:0]      prime
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                     state;
  logic [pps_pkg::VALUE_BITS-1:0] cand;
  logic [pps_pkg::DIV_BITS-1:0]   d;
  logic [pps_pkg::SQ_BITS-1:0]    sq;
  logic                           res_found;
  logic [pps_pkg::VALUE_BITS-1:0] res_prime;
  logic                           in_accept;
  logic                           sq_past;
  logic                           div_start;
  logic                           out_free;
  pps_pkg::pps_div_status_t       div_status;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  // Once the divisor squared exceeds the candidate, no divisor was found.
  assign sq_past   = sq > {2'b00, cand};
  assign div_start = (state == S_CHECK) && !sq_past;
  assign out_free  = !out_valid || !out_stall;

  pps_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cand),
    .divisor  (d),
    .status   (div_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (value < pps_pkg::VALUE_BITS'(3)) begin
              state <= S_FINISH;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (sq_past) begin
            state <= S_FINISH;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            state <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          cand      <= value - pps_pkg::VALUE_BITS'(1);
          d         <= pps_pkg::DIV_BITS'(2);
          sq        <= pps_pkg::SQ_BITS'(4);
          res_found <= 1'b0;
          res_prime <= '0;
        end
      end
      S_CHECK: begin
        if (sq_past) begin
          res_found <= 1'b1;
          res_prime <= cand;
        end
      end
      S_DIV: begin
        if (div_status.done) begin
          if (div_status.zero) begin
            // Composite: move to the next lower candidate and restart at two.
            cand <= cand - pps_pkg::VALUE_BITS'(1);
            d    <= pps_pkg::DIV_BITS'(2);
            sq   <= pps_pkg::SQ_BITS'(4);
          end else begin
            // (d + 1)^2 = d^2 + 2d + 1
            d  <= d + pps_pkg::DIV_BITS'(1);
            sq <= sq + pps_pkg::SQ_BITS'({d, 1'b1});
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          found <= res_found;
          prime <= res_prime;
        end
      end
      default: begin
      end
    endcase
  end

`include "previous_prime_search_unit_macros.svh"

  `PPS_ASSERT_SAME(a_idle_div_quiet, state == S_IDLE, !div_status.busy)
  `PPS_ASSERT_SAME(a_cand_min, state == S_CHECK, cand >= pps_pkg::VALUE_BITS'(2))
  `PPS_ASSERT_SAME(a_not_found_zero, out_valid && !found, prime == '0)
  `PPS_ASSERT_NEXT(a_div_launch, div_start, state == S_DIV && div_status.busy)

endmodule

`default_nettype wire
